@@ sv/ffa_pkg.sv @@
`timescale 1ns / 1ps
package ffa_pkg;
   localparam int REGION_BYTES = 4096;
   localparam int ADDR_W = 12;
   localparam int SIZE_W = 13;
   localparam logic [ADDR_W-1:0] FIRST_DATA = 12'd16;
   localparam logic [SIZE_W-1:0] BLOCK_HDR = 13'd8;
   localparam logic [SIZE_W-1:0] RESET_TOTAL = 13'd4096;
   localparam logic [SIZE_W-1:0] MAX_STEPS = 13'd4096;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FORM, S_A_WALK, S_F_SIZE, S_F_WALK, S_F_MERGE, S_WR1, S_WR2
   } state_type;

   typedef struct packed {
      logic              size_en;
      logic [ADDR_W-1:0] size_addr;
      logic [SIZE_W-1:0] size_data;
      logic              link_en;
      logic [ADDR_W-1:0] link_addr;
      logic [ADDR_W-1:0] link_data;
      logic              head_en;
      logic [ADDR_W-1:0] head_data;
   } wr_slot_type;

   localparam wr_slot_type SLOT_NONE = '0;

   // point pred (or the list head) at val
   function automatic wr_slot_type set_link(wr_slot_type s, logic [ADDR_W-1:0] pred,
                                            logic [ADDR_W-1:0] val);
      wr_slot_type r;
      r = s;
      if (pred == '0) begin
         r.head_en = 1'b1;
         r.head_data = val;
      end else begin
         r.link_en = 1'b1;
         r.link_addr = pred;
         r.link_data = val;
      end
      return r;
   endfunction
endpackage

@@ sv/ffa_req_if.sv @@
`timescale 1ns / 1ps
interface ffa_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [12:0] request_size;
   logic [11:0] block_address;
   modport source (output valid, command, request_size, block_address, input ready);
   modport sink (input valid, command, request_size, block_address, output ready);
endinterface

interface ffa_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] address;
   logic        ok;
   modport source (output valid, address, ok, input ready);
   modport sink (input valid, address, ok, output ready);
endinterface

@@ sv/first_fit_free_list_allocator_core.sv @@
`timescale 1ns / 1ps
// Allocate: one header read per cycle along the free list up to the first fit, then two
// write-backs before the response; a miss responds straight from the walk, with no write-back.
// Free: size read, walk over the free list, merge, then two write-backs before the response;
// range failures respond from acceptance or the size read. One transaction at a time; the next
// is accepted no earlier than the edge its response leaves. Reset is synchronous, active high;
// a clearing pass zeroes 4096 headers and forms the region (total_size 4096) before traffic.
module first_fit_free_list_allocator_core (
   input  logic        clock,
   input  logic        reset,
   ffa_req_if.sink     req_channel,
   ffa_rsp_if.source   rsp_channel,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int AW = ffa_pkg::ADDR_W;
   localparam int SW = ffa_pkg::SIZE_W;

   logic [SW-1:0] size_mem [ffa_pkg::REGION_BYTES];
   logic [AW-1:0] link_mem [ffa_pkg::REGION_BYTES];
   logic [SW-1:0] size_q;
   logic [AW-1:0] link_q;

   ffa_pkg::state_type state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic form_pend_ff, form_pend_in;
   logic [SW-1:0] form_size_ff, form_size_in;
   logic [SW-1:0] total_ff, total_in;
   logic valid_ff, valid_in;
   logic [AW-1:0] head_ff, head_in;
   logic [SW-1:0] csr_ff, csr_in;
   logic [SW-1:0] req_size_ff, req_size_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [SW-1:0] fsize_ff, fsize_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] pred_ff, pred_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic [SW-1:0] prev_size_ff, prev_size_in;
   logic [AW-1:0] next_ff, next_in;
   logic [SW-1:0] next_size_ff, next_size_in;
   logic [AW-1:0] next_link_ff, next_link_in;
   ffa_pkg::wr_slot_type slot1_ff, slot1_in, slot2_ff, slot2_in, wslot;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic res_ok_ff, res_ok_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic rsp_ok_ff, rsp_ok_in;

   logic rd_en;
   logic [AW-1:0] rd_addr;
   logic we;
   logic [AW-1:0] w_size_addr, w_link_addr;
   logic [SW-1:0] w_size_data;
   logic [AW-1:0] w_link_data;
   logic w_size_en, w_link_en;

   logic req_fire, cfg_wr, finish, fin_ok;
   logic [AW-1:0] fin_addr;
   logic [SW-1:0] cfg_val, cfg_sat;
   logic [13:0] nb, a_end, c_end, f_end;
   logic [SW-1:0] diff;
   logic nosplit, c1, c2, brk;
   logic [AW-1:0] np, nn;
   logic [SW-1:0] steps_nx;

   assign pready = 1'b1;
   assign prdata = {19'd0, csr_ff};
   assign req_channel.ready = (state_ff == ffa_pkg::S_IDLE) && !form_pend_ff &&
                              (!rsp_valid_ff || rsp_channel.ready);
   assign req_fire = req_channel.valid && req_channel.ready;
   assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
   assign cfg_val = pwdata[SW-1:0];
   assign cfg_sat = (cfg_val > ffa_pkg::RESET_TOTAL) ? ffa_pkg::RESET_TOTAL : cfg_val;

   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.address = rsp_addr_ff;
   assign rsp_channel.ok = rsp_ok_ff;

   assign nb = {2'b0, cur_ff} + {1'b0, req_size_ff} + {1'b0, ffa_pkg::BLOCK_HDR};
   assign diff = size_q - req_size_ff;
   assign nosplit = (size_q == req_size_ff) || (diff < ffa_pkg::BLOCK_HDR) ||
                    (nb >= 14'(ffa_pkg::REGION_BYTES));
   assign a_end = {2'b0, addr_ff} + {1'b0, fsize_ff} + {1'b0, ffa_pkg::BLOCK_HDR};
   assign c_end = {2'b0, cur_ff} + {1'b0, size_q} + {1'b0, ffa_pkg::BLOCK_HDR};
   assign f_end = {2'b0, addr_ff} + {1'b0, size_q};
   assign c1 = (c_end == {2'b0, addr_ff});
   assign c2 = ({2'b0, cur_ff} == a_end);
   assign np = c1 ? cur_ff : prev_ff;
   assign nn = c2 ? cur_ff : next_ff;
   assign brk = (c1 && next_ff != '0) || (c2 && np != '0);
   assign steps_nx = steps_ff + 13'd1;

   always_comb begin
      state_in = state_ff;
      clr_cnt_in = clr_cnt_ff;
      form_pend_in = form_pend_ff;
      form_size_in = form_size_ff;
      total_in = total_ff;
      valid_in = valid_ff;
      head_in = head_ff;
      csr_in = csr_ff;
      req_size_in = req_size_ff;
      addr_in = addr_ff;
      fsize_in = fsize_ff;
      cur_in = cur_ff;
      pred_in = pred_ff;
      steps_in = steps_ff;
      prev_in = prev_ff;
      prev_size_in = prev_size_ff;
      next_in = next_ff;
      next_size_in = next_size_ff;
      next_link_in = next_link_ff;
      slot1_in = slot1_ff;
      slot2_in = slot2_ff;
      res_addr_in = res_addr_ff;
      res_ok_in = res_ok_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      finish = 1'b0;
      fin_ok = 1'b0;
      fin_addr = '0;
      wslot = ffa_pkg::SLOT_NONE;
      we = 1'b0;

      unique case (state_ff)
         ffa_pkg::S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 12'd1;
            if (clr_cnt_ff == '1) state_in = ffa_pkg::S_IDLE;
         end
         ffa_pkg::S_FORM: begin
            form_pend_in = 1'b0;
            state_in = ffa_pkg::S_IDLE;
         end
         ffa_pkg::S_IDLE: begin
            if (form_pend_ff) begin
               state_in = ffa_pkg::S_FORM;
            end else if (req_fire) begin
               req_size_in = req_channel.request_size;
               addr_in = req_channel.block_address;
               pred_in = '0;
               steps_in = '0;
               prev_in = '0;
               next_in = '0;
               cur_in = head_ff;
               if (req_channel.command == ffa_pkg::CMD_ALLOC) begin
                  if (!valid_ff || head_ff == '0) begin
                     finish = 1'b1;
                  end else begin
                     rd_en = 1'b1;
                     rd_addr = head_ff;
                     state_in = ffa_pkg::S_A_WALK;
                  end
               end else begin
                  if (!valid_ff || req_channel.block_address < ffa_pkg::FIRST_DATA) begin
                     finish = 1'b1;
                  end else begin
                     rd_en = 1'b1;
                     rd_addr = req_channel.block_address;
                     state_in = ffa_pkg::S_F_SIZE;
                  end
               end
            end
         end
         ffa_pkg::S_A_WALK: begin
            if (size_q >= req_size_ff) begin
               if (nosplit) begin
                  slot1_in = ffa_pkg::set_link(ffa_pkg::SLOT_NONE, pred_ff, link_q);
                  slot2_in = ffa_pkg::SLOT_NONE;
               end else begin
                  slot1_in = ffa_pkg::SLOT_NONE;
                  slot1_in.size_en = 1'b1;
                  slot1_in.size_addr = nb[AW-1:0];
                  slot1_in.size_data = diff - ffa_pkg::BLOCK_HDR;
                  slot1_in.link_en = 1'b1;
                  slot1_in.link_addr = nb[AW-1:0];
                  slot1_in.link_data = link_q;
                  slot2_in = ffa_pkg::SLOT_NONE;
                  slot2_in.size_en = 1'b1;
                  slot2_in.size_addr = cur_ff;
                  slot2_in.size_data = req_size_ff;
                  slot2_in = ffa_pkg::set_link(slot2_in, pred_ff, nb[AW-1:0]);
               end
               res_addr_in = cur_ff;
               res_ok_in = 1'b1;
               state_in = ffa_pkg::S_WR1;
            end else begin
               pred_in = cur_ff;
               steps_in = steps_nx;
               if (link_q == '0 || steps_nx == ffa_pkg::MAX_STEPS) begin
                  finish = 1'b1;
                  state_in = ffa_pkg::S_IDLE;
               end else begin
                  cur_in = link_q;
                  rd_en = 1'b1;
                  rd_addr = link_q;
               end
            end
         end
         ffa_pkg::S_F_SIZE: begin
            fsize_in = size_q;
            if (f_end > {1'b0, total_ff}) begin
               finish = 1'b1;
               state_in = ffa_pkg::S_IDLE;
            end else if (head_ff == '0) begin
               state_in = ffa_pkg::S_F_MERGE;
            end else begin
               rd_en = 1'b1;
               rd_addr = head_ff;
               state_in = ffa_pkg::S_F_WALK;
            end
         end
         ffa_pkg::S_F_WALK: begin
            prev_in = np;
            next_in = nn;
            if (c1) prev_size_in = size_q;
            if (c2) begin
               next_size_in = size_q;
               next_link_in = link_q;
            end
            if (brk) begin
               state_in = ffa_pkg::S_F_MERGE;
            end else begin
               if (nn == '0) pred_in = cur_ff;
               steps_in = steps_nx;
               if (link_q == '0 || steps_nx == ffa_pkg::MAX_STEPS) begin
                  state_in = ffa_pkg::S_F_MERGE;
               end else begin
                  cur_in = link_q;
                  rd_en = 1'b1;
                  rd_addr = link_q;
               end
            end
         end
         ffa_pkg::S_F_MERGE: begin
            slot1_in = ffa_pkg::SLOT_NONE;
            slot2_in = ffa_pkg::SLOT_NONE;
            if (prev_ff != '0 && next_ff != '0) begin
               slot1_in.size_en = 1'b1;
               slot1_in.size_addr = prev_ff;
               slot1_in.size_data = prev_size_ff + ffa_pkg::BLOCK_HDR + ffa_pkg::BLOCK_HDR
                                    + fsize_ff + next_size_ff;
               slot1_in = ffa_pkg::set_link(slot1_in, pred_ff, next_link_ff);
            end else if (prev_ff != '0) begin
               slot1_in.size_en = 1'b1;
               slot1_in.size_addr = prev_ff;
               slot1_in.size_data = prev_size_ff + ffa_pkg::BLOCK_HDR + fsize_ff;
            end else if (next_ff != '0) begin
               slot1_in = ffa_pkg::set_link(slot1_in, pred_ff, addr_ff);
               slot1_in.size_en = 1'b1;
               slot1_in.size_addr = addr_ff;
               slot1_in.size_data = fsize_ff + ffa_pkg::BLOCK_HDR + next_size_ff;
               slot2_in.link_en = 1'b1;
               slot2_in.link_addr = addr_ff;
               slot2_in.link_data = next_link_ff;
            end else begin
               slot1_in.link_en = 1'b1;
               slot1_in.link_addr = addr_ff;
               slot1_in.link_data = head_ff;
               slot1_in.head_en = 1'b1;
               slot1_in.head_data = addr_ff;
            end
            res_addr_in = '0;
            res_ok_in = 1'b1;
            state_in = ffa_pkg::S_WR1;
         end
         ffa_pkg::S_WR1: begin
            wslot = slot1_ff;
            we = 1'b1;
            state_in = ffa_pkg::S_WR2;
         end
         ffa_pkg::S_WR2: begin
            wslot = slot2_ff;
            we = 1'b1;
            finish = 1'b1;
            fin_ok = res_ok_ff;
            fin_addr = res_addr_ff;
            state_in = ffa_pkg::S_IDLE;
         end
         default: state_in = ffa_pkg::S_IDLE;
      endcase

      if (we && wslot.head_en) head_in = wslot.head_data;

      if (cfg_wr) begin
         csr_in = cfg_val;
         if (cfg_sat <= 13'(ffa_pkg::FIRST_DATA)) begin
            valid_in = 1'b0;
         end else begin
            total_in = cfg_sat;
            valid_in = 1'b1;
            head_in = ffa_pkg::FIRST_DATA;
            form_size_in = cfg_sat - 13'(ffa_pkg::FIRST_DATA);
            form_pend_in = 1'b1;
         end
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in = fin_addr;
         rsp_ok_in = fin_ok;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
         rsp_addr_in = rsp_addr_ff;
         rsp_ok_in = rsp_ok_ff;
      end
   end

   always_comb begin
      w_size_en = 1'b0;
      w_link_en = 1'b0;
      w_size_addr = wslot.size_addr;
      w_link_addr = wslot.link_addr;
      w_size_data = wslot.size_data;
      w_link_data = wslot.link_data;
      if (state_ff == ffa_pkg::S_CLEAR) begin
         w_size_en = 1'b1;
         w_link_en = 1'b1;
         w_size_addr = clr_cnt_ff;
         w_link_addr = clr_cnt_ff;
         w_size_data = '0;
         w_link_data = '0;
      end else if (state_ff == ffa_pkg::S_FORM) begin
         w_size_en = 1'b1;
         w_link_en = 1'b1;
         w_size_addr = ffa_pkg::FIRST_DATA;
         w_link_addr = ffa_pkg::FIRST_DATA;
         w_size_data = form_size_ff;
         w_link_data = '0;
      end else if (we) begin
         w_size_en = wslot.size_en;
         w_link_en = wslot.link_en;
      end
   end

   always_ff @(posedge clock) begin
      if (w_size_en) size_mem[w_size_addr] <= w_size_data;
      if (w_link_en) link_mem[w_link_addr] <= w_link_data;
      if (rd_en) begin
         size_q <= size_mem[rd_addr];
         link_q <= link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::S_CLEAR;
         clr_cnt_ff <= '0;
         form_pend_ff <= 1'b1;
         form_size_ff <= ffa_pkg::RESET_TOTAL - 13'(ffa_pkg::FIRST_DATA);
         total_ff <= ffa_pkg::RESET_TOTAL;
         valid_ff <= 1'b1;
         head_ff <= ffa_pkg::FIRST_DATA;
         csr_ff <= ffa_pkg::RESET_TOTAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         form_pend_ff <= form_pend_in;
         form_size_ff <= form_size_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
         head_ff <= head_in;
         csr_ff <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_size_ff <= req_size_in;
      addr_ff <= addr_in;
      fsize_ff <= fsize_in;
      cur_ff <= cur_in;
      pred_ff <= pred_in;
      steps_ff <= steps_in;
      prev_ff <= prev_in;
      prev_size_ff <= prev_size_in;
      next_ff <= next_in;
      next_size_ff <= next_size_in;
      next_link_ff <= next_link_in;
      slot1_ff <= slot1_in;
      slot2_ff <= slot2_in;
      res_addr_ff <= res_addr_in;
      res_ok_ff <= res_ok_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_ok_ff <= rsp_ok_in;
   end
endmodule

@@ verif/tb_first_fit_free_list_allocator_core.sv @@
`timescale 1ns / 1ps
module tb_first_fit_free_list_allocator_core;

   // Golden allocator: free-list walk over shadow header stores.
   class alloc_scoreboard;
      logic [ffa_pkg::SIZE_W-1:0] hsize[ffa_pkg::REGION_BYTES];
      logic [ffa_pkg::ADDR_W-1:0] hlink[ffa_pkg::REGION_BYTES];
      int unsigned head;
      bit region_ok;
      int unsigned total;
      logic [ffa_pkg::ADDR_W-1:0] exp_addr[$];
      bit exp_ok[$];
      int errors;

      function void reset_state();
         foreach (hsize[i]) begin
            hsize[i] = '0;
            hlink[i] = '0;
         end
         head = 16;
         region_ok = 1;
         total = ffa_pkg::REGION_BYTES;
         form(ffa_pkg::REGION_BYTES);
      endfunction

      function void form(int unsigned t);
         if (t > ffa_pkg::REGION_BYTES) t = ffa_pkg::REGION_BYTES;
         if (t <= 16) begin
            region_ok = 0;
            return;
         end
         total = t;
         region_ok = 1;
         head = 16;
         hsize[16] = ffa_pkg::SIZE_W'(t - 16);
         hlink[16] = '0;
      endfunction

      function void relink(int unsigned pred, int unsigned val);
         if (pred == 0) head = val & 12'hFFF;
         else if (pred < ffa_pkg::REGION_BYTES) hlink[pred] = ffa_pkg::ADDR_W'(val);
      endfunction

      function void alloc(int unsigned req, output int unsigned addr, output bit ok);
         int unsigned pred, cur, steps, s, nb;
         pred = 0;
         cur = head;
         steps = 0;
         addr = 0;
         ok = 0;
         if (!region_ok) return;
         while (cur != 0 && cur < ffa_pkg::REGION_BYTES && steps < ffa_pkg::REGION_BYTES) begin
            s = hsize[cur];
            if (s < req) begin
               pred = cur;
               cur = hlink[cur];
               steps++;
               continue;
            end
            nb = cur + req + 8;
            if (s == req || s - req < 8 || nb >= ffa_pkg::REGION_BYTES) begin
               relink(pred, hlink[cur]);
            end else begin
               hsize[nb] = ffa_pkg::SIZE_W'(s - req - 8);
               hlink[nb] = hlink[cur];
               relink(pred, nb);
               hsize[cur] = ffa_pkg::SIZE_W'(req);
            end
            ok = 1;
            addr = cur;
            return;
         end
      endfunction

      function bit release_block(int unsigned addr);
         int unsigned fsize, prv, nxt, pred, cur, steps;
         prv = 0;
         nxt = 0;
         pred = 0;
         steps = 0;
         if (!region_ok || addr < 16 || addr >= ffa_pkg::REGION_BYTES) return 0;
         fsize = hsize[addr];
         if (addr + fsize > total) return 0;
         cur = head;
         while (cur != 0 && cur < ffa_pkg::REGION_BYTES && steps < ffa_pkg::REGION_BYTES) begin
            if (cur + hsize[cur] + 8 == addr) begin
               prv = cur;
               if (nxt != 0) break;
            end
            if (cur == addr + fsize + 8) begin
               nxt = cur;
               if (prv != 0) break;
            end
            if (nxt == 0) pred = cur;
            cur = hlink[cur];
            steps++;
         end
         if (prv != 0 && nxt != 0) begin
            hsize[prv] = ffa_pkg::SIZE_W'(hsize[prv] + 16 + fsize + hsize[nxt]);
            relink(pred, hlink[nxt]);
         end else if (prv != 0) begin
            hsize[prv] = ffa_pkg::SIZE_W'(hsize[prv] + 8 + fsize);
         end else if (nxt != 0) begin
            relink(pred, addr);
            hsize[addr] = ffa_pkg::SIZE_W'(fsize + 8 + hsize[nxt]);
            hlink[addr] = hlink[nxt];
         end else begin
            hlink[addr] = ffa_pkg::ADDR_W'(head);
            head = addr;
         end
         return 1;
      endfunction

      function void note_request(logic cmd, logic [12:0] req, logic [11:0] addr);
         int unsigned a;
         bit ok;
         if (cmd == ffa_pkg::CMD_ALLOC) begin
            alloc(req, a, ok);
         end else begin
            a = 0;
            ok = release_block(addr);
         end
         exp_addr.push_back(ffa_pkg::ADDR_W'(a));
         exp_ok.push_back(ok);
      endfunction

      function void check_result(logic [11:0] addr, logic ok);
         logic [11:0] ea;
         bit eo;
         if (exp_addr.size() == 0) begin
            $display("%0t: unexpected result address %0d ok %0b", $time, addr, ok);
            errors++;
            return;
         end
         ea = exp_addr.pop_front();
         eo = exp_ok.pop_front();
         if (addr !== ea) begin
            $display("%0t: address expected %0d actual %0d", $time, ea, addr);
            errors++;
         end
         if (ok !== eo) begin
            $display("%0t: ok expected %0b actual %0b", $time, eo, ok);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   ffa_req_if req_bus();
   ffa_rsp_if rsp_bus();
   alloc_scoreboard sb;
   logic [11:0] granted[$];
   bit hold_rsp = 0;
   bit stim_done = 0;

   always #1 clock = ~clock;

   first_fit_free_list_allocator_core dut (
      .clock(clock), .reset(reset), .req_channel(req_bus.sink), .rsp_channel(rsp_bus.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   initial begin
      req_bus.valid = 0;
      req_bus.command = 0;
      req_bus.request_size = 0;
      req_bus.block_address = 0;
      rsp_bus.ready = 0;
   end

   // score on the same edge the handshake completes
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_request(req_bus.command, req_bus.request_size, req_bus.block_address);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_bus.ok && rsp_bus.address != 0) granted.push_back(rsp_bus.address);
         sb.check_result(rsp_bus.address, rsp_bus.ok);
      end
   end

   // receiver: random stall per result, plus one long hold-off
   initial begin
      int w;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 0;
            @(posedge clock);
         end else begin
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            if (w > 0) begin
               rsp_bus.ready <= 0;
               repeat (w) @(posedge clock);
            end
            rsp_bus.ready <= 1;
            do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         end
      end
   end

   // valid stays high after acceptance; the next send or drain() updates it
   task automatic send(logic cmd, logic [12:0] sz, logic [11:0] addr, int gap);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.command <= cmd;
      req_bus.request_size <= sz;
      req_bus.block_address <= addr;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (sb.exp_addr.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_total(logic [12:0] t);
      drain();
      psel <= 1;
      pwrite <= 1;
      paddr <= 2'd0;
      pwdata <= {19'd0, t};
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.form(t);
      granted.delete();
   endtask

   function automatic int draw_gap();
      return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
   endfunction

   task automatic random_phase(int n, int max_size);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 9);
         if (k < 5) begin
            send(ffa_pkg::CMD_ALLOC, 13'($urandom_range(0, max_size)), 12'($urandom),
                 draw_gap());
         end else if (k < 9 && granted.size() != 0) begin
            int j;
            logic [11:0] a;
            j = $urandom_range(0, granted.size() - 1);
            a = granted[j];
            granted.delete(j);
            send(ffa_pkg::CMD_FREE, 13'($urandom), a, draw_gap());
         end else begin
            send(1'($urandom_range(0, 1)), 13'($urandom), 12'($urandom), draw_gap());
         end
      end
   endtask

   initial begin
      sb = new();
      sb.errors = 0;
      sb.reset_state();
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed: extremes, exact fit, tight split, small and oversized region
      send(ffa_pkg::CMD_ALLOC, 13'd0, 12'd0, 0);
      send(ffa_pkg::CMD_ALLOC, 13'd100, 12'hFFF, 0);
      send(ffa_pkg::CMD_ALLOC, 13'd4096, 12'd0, 0);
      send(ffa_pkg::CMD_ALLOC, 13'h1FFF, 12'd0, 0);
      send(ffa_pkg::CMD_FREE, 13'h1FFF, 12'd16, 0);
      send(ffa_pkg::CMD_FREE, 13'd0, 12'd24, 0);
      send(ffa_pkg::CMD_FREE, 13'd0, 12'd0, 0);
      send(ffa_pkg::CMD_FREE, 13'd0, 12'hFFF, 0);
      send(ffa_pkg::CMD_FREE, 13'd0, 12'd2000, 0);
      send(ffa_pkg::CMD_ALLOC, 13'd3940, 12'd0, 0);
      write_total(13'd64);
      send(ffa_pkg::CMD_ALLOC, 13'd48, 12'd0, 0);
      send(ffa_pkg::CMD_FREE, 13'd0, 12'd16, 0);
      send(ffa_pkg::CMD_ALLOC, 13'd44, 12'd0, 0);
      send(ffa_pkg::CMD_ALLOC, 13'd0, 12'd0, 0);
      write_total(13'd16);
      send(ffa_pkg::CMD_ALLOC, 13'd0, 12'd0, 0);
      send(ffa_pkg::CMD_FREE, 13'd0, 12'd16, 0);
      write_total(13'h1FFF);
      send(ffa_pkg::CMD_ALLOC, 13'd4080, 12'd0, 0);
      send(ffa_pkg::CMD_FREE, 13'd0, 12'd16, 0);
      write_total(13'd0);
      send(ffa_pkg::CMD_ALLOC, 13'd1, 12'd0, 0);
      write_total(13'd4096);
      granted.delete();
      random_phase(200, 200);
      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            random_phase(20, 100);
            drain();
         end
      join
      random_phase(150, 60);
      write_total(13'd512);
      random_phase(150, 80);
      write_total(13'd4096);
      random_phase(200, 400);
      drain();
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      if (sb.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end
endmodule

@@ filelist.f @@
sv/ffa_pkg.sv
sv/ffa_req_if.sv
sv/first_fit_free_list_allocator_core.sv
verif/tb_first_fit_free_list_allocator_core.sv
